/* src/running_mean_std_dev_defines.svh */
// assertion macros shared by the running mean / deviation rtl
// no dependencies; included by files that carry concurrent checks
`ifndef RUNNING_MEAN_STD_DEV_DEFINES_SVH
`define RUNNING_MEAN_STD_DEV_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define RMSD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("rmsd same-cycle check failed");

// condition must hold in the cycle after the trigger
`define RMSD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("rmsd next-cycle check failed");

`endif

/* src/rmsd_pkg.sv */
// shared types and codes for the running mean / deviation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rmsd_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    localparam logic [23:0] MEAN_POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] MEAN_NEG_MAX = 24'h800000;
    localparam logic [23:0] DEV_MAX      = 24'hFFFFFF;
    localparam logic [15:0] COUNT_OUT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] sample;
    } item_t;

    typedef struct packed {
        logic [15:0]        sample_count;
        logic signed [23:0] mean_q8;
        logic [23:0]        deviation_q8;
        logic               empty_res;
        logic               saturated;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_MDIV,
        BK_SQRT,
        BK_DDIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

/* src/rmsd_front.sv */
// front part: accumulates count, sum and sum of squares, flags reports
// depends on rmsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmsd_front
    import rmsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
)(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     accept,
    input  item_t                                    item,
    output logic [COUNT_BITS-1:0]                    count,
    output logic signed [SAMPLE_BITS+COUNT_BITS-1:0] sum,
    output logic [2*SAMPLE_BITS+COUNT_BITS-3:0]      sqsum,
    output logic                                     sat,
    output logic                                     report
);

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS - 2;
    localparam int RAW_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

    logic [COUNT_BITS-1:0]     count_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]           sqsum_reg;
    logic                      sat_reg;

    logic [RAW_W-1:0]          raw_ext;
    logic [SAMPLE_BITS-1:0]    raw;
    logic [SAMPLE_BITS-1:0]    mag;
    logic [2*SAMPLE_BITS-1:0]  square;

    // low sample bits read as two's complement
    assign raw_ext = RAW_W'($unsigned(item.sample));
    assign raw     = raw_ext[SAMPLE_BITS-1:0];
    assign mag     = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
    assign square  = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (accept)
        begin
            unique case (item.operation)
                OP_ADD:
                begin
                    if (&count_reg)
                    begin
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        sum_reg   <= sum_reg + SUM_W'($signed(raw));
                        sqsum_reg <= sqsum_reg + SQ_W'(square);
                    end
                end
                OP_CLEAR:
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    sqsum_reg <= '0;
                    sat_reg   <= 1'b0;
                end
                default:
                begin
                    // report reads state only, unused code is dropped
                end
            endcase
        end
    end

    assign count  = count_reg;
    assign sum    = sum_reg;
    assign sqsum  = sqsum_reg;
    assign sat    = sat_reg;
    assign report = accept && (item.operation == OP_REPORT);

endmodule

`default_nettype wire

/* src/rmsd_fifo.sv */
// two-entry queue of accumulator snapshots between front and back
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module rmsd_fifo #(
    parameter int WIDTH = 8
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = data_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* src/rmsd_back.sv */
// back part: serial multiply, divide and square root for one report
// depends on rmsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmsd_back
    import rmsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
)(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     snap_valid,
    output logic                                     snap_pop,
    input  logic [COUNT_BITS-1:0]                    snap_count,
    input  logic signed [SAMPLE_BITS+COUNT_BITS-1:0] snap_sum,
    input  logic [2*SAMPLE_BITS+COUNT_BITS-3:0]      snap_sqsum,
    input  logic                                     snap_sat,
    output logic                                     empty,
    input  logic                                     pop,
    output result_t                                  result
);

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int MW    = SUM_W - 1;
    localparam int PW    = 2 * MW;
    localparam int VW    = PW + 16;
    localparam int RW    = VW / 2;
    localparam int DIVW  = MW + 8;
    localparam int CW    = $clog2(DIVW + 1);
    localparam int EXW   = (DIVW > 25) ? DIVW : 25;
    localparam int NW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    back_state_t state_reg, state_next;

    logic [CW-1:0]         step_reg;
    logic                  out_valid_reg;
    result_t               result_reg;

    logic [COUNT_BITS-1:0] n_reg;
    logic                  neg_reg;
    logic                  sat_reg;
    logic [MW-1:0]         mag_reg;
    logic [PW-1:0]         a_mcand_reg, b_mcand_reg, acc_a_reg, acc_b_reg;
    logic [COUNT_BITS-1:0] a_mplier_reg;
    logic [MW-1:0]         b_mplier_reg;
    logic [DIVW-1:0]       dq_reg;
    logic [COUNT_BITS:0]   dr_reg;
    logic [VW-1:0]         x_reg;
    logic [RW+1:0]         rem_reg;
    logic [RW-1:0]         root_reg;
    logic [23:0]           mean_reg;
    logic [23:0]           dev_reg;

    logic                  step_done;
    logic                  iterating;
    logic                  out_load;
    logic [SUM_W-1:0]      snap_abs;
    logic [MW-1:0]         snap_mag;
    logic [COUNT_BITS:0]   dr_sh, dr_new;
    logic                  div_ge;
    logic [DIVW-1:0]       dq_new;
    logic [RW+1:0]         rem_sh, rem_new, trial;
    logic                  sq_ge;
    logic [RW-1:0]         root_new;
    logic [PW-1:0]         var_diff;
    logic [EXW-1:0]        q_ext;
    logic [EXW-1:0]        q_neg;
    logic [23:0]           mean_val;
    logic [23:0]           dev_val;
    logic [NW-1:0]         n_ext;

    assign snap_abs = snap_sum[SUM_W-1] ? SUM_W'(~snap_sum + 1'b1) : SUM_W'(snap_sum);
    assign snap_mag = snap_abs[MW-1:0];

    // restoring divide step, one quotient bit
    assign dr_sh  = {dr_reg[COUNT_BITS-1:0], dq_reg[DIVW-1]};
    assign div_ge = (dr_sh >= {1'b0, n_reg});
    assign dr_new = div_ge ? (dr_sh - {1'b0, n_reg}) : dr_sh;
    assign dq_new = {dq_reg[DIVW-2:0], div_ge};

    // square root step, two radicand bits per root bit
    assign rem_sh   = {rem_reg[RW-1:0], x_reg[VW-1:VW-2]};
    assign trial    = {root_reg, 2'b01};
    assign sq_ge    = (rem_sh >= trial);
    assign rem_new  = sq_ge ? (rem_sh - trial) : rem_sh;
    assign root_new = {root_reg[RW-2:0], sq_ge};

    assign var_diff = acc_a_reg - acc_b_reg;

    // clamp quotients into the 24-bit result fields
    assign q_ext    = EXW'(dq_new);
    assign q_neg    = ~q_ext + 1'b1;
    assign mean_val = neg_reg
                    ? ((q_ext > EXW'(MEAN_NEG_MAX)) ? MEAN_NEG_MAX : q_neg[23:0])
                    : ((q_ext > EXW'(MEAN_POS_MAX)) ? MEAN_POS_MAX : q_ext[23:0]);
    assign dev_val  = (q_ext > EXW'(DEV_MAX)) ? DEV_MAX : q_ext[23:0];
    assign n_ext    = NW'(n_reg);

    always_comb begin
        unique case (state_reg)
            BK_MUL:  step_done = (step_reg == CW'(MW - 1));
            BK_MDIV: step_done = (step_reg == CW'(DIVW - 1));
            BK_SQRT: step_done = (step_reg == CW'(RW - 1));
            BK_DDIV: step_done = (step_reg == CW'(DIVW - 1));
            default: step_done = 1'b0;
        endcase
    end

    assign iterating = (state_reg == BK_MUL) || (state_reg == BK_MDIV)
                    || (state_reg == BK_SQRT) || (state_reg == BK_DDIV);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        snap_pop   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (snap_valid)
                begin
                    snap_pop   = 1'b1;
                    state_next = (snap_count == '0) ? BK_DONE : BK_MUL;
                end
            end
            BK_MUL:
            begin
                if (step_done)
                begin
                    state_next = BK_MDIV;
                end
            end
            BK_MDIV:
            begin
                if (step_done)
                begin
                    state_next = BK_SQRT;
                end
            end
            BK_SQRT:
            begin
                if (step_done)
                begin
                    state_next = BK_DDIV;
                end
            end
            BK_DDIV:
            begin
                if (step_done)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (iterating && !step_done)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (snap_pop)
                begin
                    n_reg        <= snap_count;
                    neg_reg      <= snap_sum[SUM_W-1];
                    sat_reg      <= snap_sat;
                    mag_reg      <= snap_mag;
                    a_mcand_reg  <= PW'(snap_sqsum);
                    a_mplier_reg <= snap_count;
                    b_mcand_reg  <= PW'(snap_mag);
                    b_mplier_reg <= snap_mag;
                    acc_a_reg    <= '0;
                    acc_b_reg    <= '0;
                    mean_reg     <= '0;
                    dev_reg      <= '0;
                end
            end
            BK_MUL:
            begin
                // n * sumsq and |sum| * |sum| side by side
                if (a_mplier_reg[0])
                begin
                    acc_a_reg <= acc_a_reg + a_mcand_reg;
                end
                if (b_mplier_reg[0])
                begin
                    acc_b_reg <= acc_b_reg + b_mcand_reg;
                end
                a_mcand_reg  <= a_mcand_reg << 1;
                b_mcand_reg  <= b_mcand_reg << 1;
                a_mplier_reg <= a_mplier_reg >> 1;
                b_mplier_reg <= b_mplier_reg >> 1;
                if (step_done)
                begin
                    dq_reg <= {mag_reg, 8'b0};
                    dr_reg <= '0;
                end
            end
            BK_MDIV:
            begin
                dq_reg <= dq_new;
                dr_reg <= dr_new;
                if (step_done)
                begin
                    mean_reg <= mean_val;
                    x_reg    <= {var_diff, 16'b0};
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            BK_SQRT:
            begin
                x_reg    <= x_reg << 2;
                rem_reg  <= rem_new;
                root_reg <= root_new;
                if (step_done)
                begin
                    dq_reg <= root_new;
                    dr_reg <= '0;
                end
            end
            BK_DDIV:
            begin
                dq_reg <= dq_new;
                dr_reg <= dr_new;
                if (step_done)
                begin
                    dev_reg <= dev_val;
                end
            end
            BK_DONE:
            begin
                if (out_load)
                begin
                    result_reg.sample_count <= (n_ext > NW'(COUNT_OUT_MAX))
                                             ? COUNT_OUT_MAX : n_ext[15:0];
                    result_reg.mean_q8      <= $signed(mean_reg);
                    result_reg.deviation_q8 <= dev_reg;
                    result_reg.empty_res    <= (n_reg == '0);
                    result_reg.saturated    <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* src/running_mean_std_dev.sv */
// add and clear items: one per cycle while the queue is not full, applied in the cycle they are taken
// report: snapshot queued, then serial multiply, mean divide, square root and deviation divide in the back end
// back end runs one report at a time; a 2-deep snapshot queue buffers further reports
// push is refused (full) while that queue holds two waiting reports
// async active-low reset clears accumulators, saturation flag, queue and result valid flag
`timescale 1ns / 1ps
`default_nettype none
`include "running_mean_std_dev_defines.svh"

module running_mean_std_dev
    import rmsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS - 2;
    localparam int SNAP_W = COUNT_BITS + SUM_W + SQ_W + 1;
    // count reported once the counter has pinned at its top value
    localparam int unsigned SAT_COUNT = (COUNT_BITS >= 16) ? 65535 : ((1 << COUNT_BITS) - 1);

    // accepted item strobe
    logic                    accept;

    // live accumulators from the front
    logic [COUNT_BITS-1:0]   acc_count;
    logic signed [SUM_W-1:0] acc_sum;
    logic [SQ_W-1:0]         acc_sqsum;
    logic                    acc_sat;
    logic                    report;

    // snapshot queue toward the back
    logic [SNAP_W-1:0]       snap_wr;
    logic [SNAP_W-1:0]       snap_rd;
    logic                    snap_empty;
    logic                    snap_pop;

    logic [COUNT_BITS-1:0]   snap_count;
    logic signed [SUM_W-1:0] snap_sum;
    logic [SQ_W-1:0]         snap_sqsum;
    logic                    snap_sat;

    assign accept = push && !full;

    // front: every item lands here; add and clear finish in this cycle
    rmsd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .count  (acc_count),
        .sum    (acc_sum),
        .sqsum  (acc_sqsum),
        .sat    (acc_sat),
        .report (report)
    );

    // a report freezes the accumulators as they stand before any later item
    assign snap_wr = {acc_count, acc_sum, acc_sqsum, acc_sat};

    rmsd_fifo #(
        .WIDTH (SNAP_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (report),
        .wr_data (snap_wr),
        .full    (full),
        .rd_en   (snap_pop),
        .rd_data (snap_rd),
        .empty   (snap_empty)
    );

    assign snap_count = snap_rd[SNAP_W-1 -: COUNT_BITS];
    assign snap_sum   = $signed(snap_rd[SQ_W+SUM_W : SQ_W+1]);
    assign snap_sqsum = snap_rd[SQ_W:1];
    assign snap_sat   = snap_rd[0];

    // back: multiply, mean divide, square root, deviation divide, then result register
    rmsd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (!snap_empty),
        .snap_pop   (snap_pop),
        .snap_count (snap_count),
        .snap_sum   (snap_sum),
        .snap_sqsum (snap_sqsum),
        .snap_sat   (snap_sat),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    // an add with the counter pinned must leave the sticky flag set
    `RMSD_ASSERT_NEXT(a_sat_sticky, clk, rst_n, accept && (item.operation == OP_ADD) && (&acc_count), acc_sat)

    // an accepted report is waiting in the queue on the next cycle
    `RMSD_ASSERT_NEXT(a_report_queued, clk, rst_n, report, !snap_empty)

    // an empty report carries zero count, mean and deviation
    `RMSD_ASSERT_NOW(a_empty_zero, clk, rst_n, !empty && result.empty_res, (result.sample_count == '0) && (result.mean_q8 == '0) && (result.deviation_q8 == '0))

    // saturation is only reported with the counter at its top
    `RMSD_ASSERT_NOW(a_sat_count, clk, rst_n, !empty && result.saturated, result.sample_count == 16'(SAT_COUNT))

endmodule

`default_nettype wire
